// File: hw/rtl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// shared constants and types of the separable switch allocator
// ----------------------------------------------------------------------------
package ssa_pkg;

	// defaults of the top-level parameters
	localparam int DEF_NUM_INPUTS   = 5;
	localparam int DEF_NUM_OUTPUTS  = 5;
	localparam int DEF_VCS_PER_PORT = 4;
	localparam int DEF_VCS_PER_VNET = 2;
	localparam int DEF_AGE_BITS     = 3;

	// fixed field widths of the beats
	localparam int ROUTE_BITS        = 3;
	localparam int INPORT_FIELD_BITS = 3;
	localparam int VC_FIELD_BITS     = 2;

	// stage-one winner of one input port
	typedef struct packed {
		logic                     valid;
		logic [ROUTE_BITS-1:0]    route;
		logic [VC_FIELD_BITS-1:0] vc;
	} ssa_win_t;

	// stage-two grant of one output port
	typedef struct packed {
		logic                         grant;
		logic [INPORT_FIELD_BITS-1:0] inport;
		logic [VC_FIELD_BITS-1:0]     vc;
	} ssa_grant_t;

endpackage

// File: hw/rtl/ssa_req_if.sv
// ----------------------------------------------------------------------------
// ssa_req_if
// request channel: per-vc request, credit, route and age vectors
// ----------------------------------------------------------------------------
interface ssa_req_if #(
	parameter int NUM_VCS  = 20,
	parameter int AGE_BITS = 3
);
	import ssa_pkg::*;

	logic                           valid;
	logic                           ready;
	logic [NUM_VCS-1:0]             request_mask;
	logic [NUM_VCS-1:0]             credit_mask;
	logic [NUM_VCS*ROUTE_BITS-1:0]  route_vector;
	logic [NUM_VCS*AGE_BITS-1:0]    age_vector;

	modport source (output valid, request_mask, credit_mask, route_vector, age_vector,
		input ready);
	modport sink (input valid, request_mask, credit_mask, route_vector, age_vector,
		output ready);
endinterface

// File: hw/rtl/ssa_grant_if.sv
// ----------------------------------------------------------------------------
// ssa_grant_if
// grant channel: per-output grant bit, winning input port and vc
// ----------------------------------------------------------------------------
interface ssa_grant_if #(
	parameter int NUM_OUTPUTS = 5
);
	import ssa_pkg::*;

	logic                                   valid;
	logic                                   ready;
	logic [NUM_OUTPUTS-1:0]                 grant_mask;
	logic [NUM_OUTPUTS*INPORT_FIELD_BITS-1:0] granted_inports;
	logic [NUM_OUTPUTS*VC_FIELD_BITS-1:0]   granted_vcs;

	modport source (output valid, grant_mask, granted_inports, granted_vcs, input ready);
	modport sink (input valid, grant_mask, granted_inports, granted_vcs, output ready);
endinterface

// File: hw/rtl/ssa_vc_arb.sv
// ----------------------------------------------------------------------------
// ssa_vc_arb
// stage one: round-robin pick of one eligible vc of one input port
// ----------------------------------------------------------------------------
module ssa_vc_arb
	import ssa_pkg::*;
#(
	parameter int NUM_OUTPUTS  = DEF_NUM_OUTPUTS,
	parameter int VCS_PER_PORT = DEF_VCS_PER_PORT,
	parameter int VCS_PER_VNET = DEF_VCS_PER_VNET,
	parameter int AGE_BITS     = DEF_AGE_BITS,
	parameter int NUM_VNETS    = VCS_PER_PORT / VCS_PER_VNET,
	parameter int VNET_W       = (NUM_VNETS < 1) ? 1 : NUM_VNETS,
	parameter int VC_PTR_W     = $clog2(VCS_PER_PORT)
) (
	input  logic [VCS_PER_PORT-1:0]            req_bits,
	input  logic [VCS_PER_PORT-1:0]            cred_bits,
	input  logic [VCS_PER_PORT*ROUTE_BITS-1:0] route_bits,
	input  logic [VCS_PER_PORT*AGE_BITS-1:0]   age_bits,
	input  logic [VNET_W-1:0]                  ordered,
	input  logic [VC_PTR_W-1:0]                ptr,
	output ssa_win_t                           win
);
	localparam int CW = VC_PTR_W + 1;

	logic [VCS_PER_PORT-1:0] elig;

	for (genvar c = 0; c < VCS_PER_PORT; c++) begin : g_vc
		localparam int VN = c / VCS_PER_VNET;
		logic [ROUTE_BITS-1:0] rt;
		logic [AGE_BITS-1:0]   ag;
		logic                  blocked;
		logic                  in_range;

		assign rt = route_bits[c*ROUTE_BITS +: ROUTE_BITS];
		assign ag = age_bits[c*AGE_BITS +: AGE_BITS];
		assign in_range = ({1'b0, rt} < (ROUTE_BITS+1)'(NUM_OUTPUTS));

		if (VN < NUM_VNETS) begin : g_ord
			// in an ordered vnet, an older requesting sibling to the same output holds this vc back
			always_comb begin
				blocked = 1'b0;
				for (int k = 0; k < VCS_PER_VNET; k++) begin
					if (req_bits[VN*VCS_PER_VNET + k] &&
					    route_bits[(VN*VCS_PER_VNET + k)*ROUTE_BITS +: ROUTE_BITS] == rt &&
					    age_bits[(VN*VCS_PER_VNET + k)*AGE_BITS +: AGE_BITS] < ag)
						blocked = 1'b1;
				end
				blocked = blocked & ordered[VN];
			end
		end else begin : g_free
			assign blocked = 1'b0;
		end

		assign elig[c] = req_bits[c] & cred_bits[c] & in_range & ~blocked;
	end

	always_comb begin
		logic [CW-1:0]         idx;
		logic [VC_PTR_W-1:0]   sel;
		win = '0;
		for (int j = 0; j < VCS_PER_PORT; j++) begin
			idx = CW'(ptr) + CW'(j + 1);
			if (idx >= CW'(VCS_PER_PORT))
				idx = idx - CW'(VCS_PER_PORT);
			sel = idx[VC_PTR_W-1:0];
			if (!win.valid && elig[sel]) begin
				win.valid = 1'b1;
				win.route = route_bits[sel*ROUTE_BITS +: ROUTE_BITS];
				win.vc    = VC_FIELD_BITS'(sel);
			end
		end
	end
endmodule

// File: hw/rtl/ssa_port_arb.sv
// ----------------------------------------------------------------------------
// ssa_port_arb
// stage two: round-robin pick of one input port for one output port
// ----------------------------------------------------------------------------
module ssa_port_arb
	import ssa_pkg::*;
#(
	parameter int NUM_INPUTS = DEF_NUM_INPUTS,
	parameter int OUT_INDEX  = 0,
	parameter int IN_PTR_W   = $clog2(NUM_INPUTS)
) (
	input  ssa_win_t            wins [NUM_INPUTS],
	input  logic [IN_PTR_W-1:0] ptr,
	output ssa_grant_t          gnt
);
	localparam int CW = IN_PTR_W + 1;

	logic [NUM_INPUTS-1:0] hit;

	always_comb begin
		for (int p = 0; p < NUM_INPUTS; p++)
			hit[p] = wins[p].valid && (wins[p].route == ROUTE_BITS'(OUT_INDEX));
	end

	always_comb begin
		logic [CW-1:0]       idx;
		logic [IN_PTR_W-1:0] sel;
		gnt = '0;
		for (int j = 0; j < NUM_INPUTS; j++) begin
			idx = CW'(ptr) + CW'(j + 1);
			if (idx >= CW'(NUM_INPUTS))
				idx = idx - CW'(NUM_INPUTS);
			sel = idx[IN_PTR_W-1:0];
			if (!gnt.grant && hit[sel]) begin
				gnt.grant  = 1'b1;
				gnt.inport = INPORT_FIELD_BITS'(sel);
				gnt.vc     = wins[sel].vc;
			end
		end
	end
endmodule

// File: hw/rtl/separable_switch_allocator_core.sv
// ----------------------------------------------------------------------------
// separable_switch_allocator_core
// separable input-first round-robin switch allocator of a vc router
// ----------------------------------------------------------------------------
// usage
//   req   : one beat per allocation cycle, carrying per-vc request, credit,
//           3-bit output route and age rank (vc index = inport*vcs + vc)
//   grant : one beat per request beat, with a grant bit, winning input port
//           and winning vc per output port; ungranted fields are zero
//   cfg   : cfg_we/cfg_wdata write the ordered-vnet mask; the user must
//           write it only while idle, as the core does not enforce this
//   core  : a beat is captured in an input register, both arbiter stages
//           run in one combinational pass, the result lands in the output
//           register; one beat per cycle sustained while grants are taken
// reset
//   arst_n clears both pointer arrays, the mask and the valid flags
// stall
//   a stalled grant beat holds in the output register; the input register
//   still takes a beat, then req.ready drops until the grant is taken
// pointers
//   every accepted beat advances each vc pointer and each output pointer
// ----------------------------------------------------------------------------
module separable_switch_allocator_core
	import ssa_pkg::*;
#(
	parameter int NUM_INPUTS   = DEF_NUM_INPUTS,
	parameter int NUM_OUTPUTS  = DEF_NUM_OUTPUTS,
	parameter int VCS_PER_PORT = DEF_VCS_PER_PORT,
	parameter int VCS_PER_VNET = DEF_VCS_PER_VNET,
	parameter int AGE_BITS     = DEF_AGE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [((VCS_PER_PORT / VCS_PER_VNET) < 1 ? 1 :
	              (VCS_PER_PORT / VCS_PER_VNET))-1:0] cfg_wdata,
	ssa_req_if.sink               req,
	ssa_grant_if.source           grant
);
	localparam int NUM_VNETS = VCS_PER_PORT / VCS_PER_VNET;
	localparam int VNET_W    = (NUM_VNETS < 1) ? 1 : NUM_VNETS;
	localparam int NUM_VCS   = NUM_INPUTS * VCS_PER_PORT;
	localparam int VC_PTR_W  = $clog2(VCS_PER_PORT);
	localparam int IN_PTR_W  = $clog2(NUM_INPUTS);

	// ordered-vnet mask; bits past the vnet count stay zero
	logic [VNET_W-1:0] ordered_q;

	// round-robin pointers
	logic [VC_PTR_W-1:0] vc_ptr_q  [NUM_INPUTS];
	logic [IN_PTR_W-1:0] out_ptr_q [NUM_OUTPUTS];

	// input register: the beat and the pointers it was accepted with
	logic                          v_s1;
	logic [NUM_VCS-1:0]            req_s1;
	logic [NUM_VCS-1:0]            cred_s1;
	logic [NUM_VCS*ROUTE_BITS-1:0] route_s1;
	logic [NUM_VCS*AGE_BITS-1:0]   age_s1;
	logic [VC_PTR_W-1:0]           vc_ptr_s1  [NUM_INPUTS];
	logic [IN_PTR_W-1:0]           out_ptr_s1 [NUM_OUTPUTS];

	// output register
	logic                                     v_s2;
	logic [NUM_OUTPUTS-1:0]                   gmask_s2;
	logic [NUM_OUTPUTS*INPORT_FIELD_BITS-1:0] gports_s2;
	logic [NUM_OUTPUTS*VC_FIELD_BITS-1:0]     gvcs_s2;

	logic in_fire;
	logic adv_s2;

	ssa_win_t   wins [NUM_INPUTS];
	ssa_grant_t gnts [NUM_OUTPUTS];

	// output register frees when empty or being taken
	assign adv_s2    = ~v_s2 | grant.ready;
	assign req.ready = ~v_s1 | adv_s2;
	assign in_fire   = req.valid & req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_q <= '0;
		end else if (cfg_we) begin
			for (int v = 0; v < VNET_W; v++)
				ordered_q[v] <= (v < NUM_VNETS) ? cfg_wdata[v] : 1'b0;
		end
	end

	// pointers step on every accepted beat, granted or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_INPUTS; i++)
				vc_ptr_q[i] <= '0;
			for (int o = 0; o < NUM_OUTPUTS; o++)
				out_ptr_q[o] <= '0;
		end else if (in_fire) begin
			for (int i = 0; i < NUM_INPUTS; i++)
				vc_ptr_q[i] <= (vc_ptr_q[i] == VC_PTR_W'(VCS_PER_PORT - 1)) ?
					'0 : vc_ptr_q[i] + VC_PTR_W'(1);
			for (int o = 0; o < NUM_OUTPUTS; o++)
				out_ptr_q[o] <= (out_ptr_q[o] == IN_PTR_W'(NUM_INPUTS - 1)) ?
					'0 : out_ptr_q[o] + IN_PTR_W'(1);
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (adv_s2) begin
			v_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1   <= req.request_mask;
			cred_s1  <= req.credit_mask;
			route_s1 <= req.route_vector;
			age_s1   <= req.age_vector;
			for (int i = 0; i < NUM_INPUTS; i++)
				vc_ptr_s1[i] <= vc_ptr_q[i];
			for (int o = 0; o < NUM_OUTPUTS; o++)
				out_ptr_s1[o] <= out_ptr_q[o];
		end
	end

	// stage one: one vc per input port
	for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_in
		ssa_vc_arb #(
			.NUM_OUTPUTS  (NUM_OUTPUTS),
			.VCS_PER_PORT (VCS_PER_PORT),
			.VCS_PER_VNET (VCS_PER_VNET),
			.AGE_BITS     (AGE_BITS)
		) u_vc_arb (
			.req_bits   (req_s1[i*VCS_PER_PORT +: VCS_PER_PORT]),
			.cred_bits  (cred_s1[i*VCS_PER_PORT +: VCS_PER_PORT]),
			.route_bits (route_s1[i*VCS_PER_PORT*ROUTE_BITS +: VCS_PER_PORT*ROUTE_BITS]),
			.age_bits   (age_s1[i*VCS_PER_PORT*AGE_BITS +: VCS_PER_PORT*AGE_BITS]),
			.ordered    (ordered_q),
			.ptr        (vc_ptr_s1[i]),
			.win        (wins[i])
		);
	end

	// stage two: one input port per output port
	for (genvar o = 0; o < NUM_OUTPUTS; o++) begin : g_out
		ssa_port_arb #(
			.NUM_INPUTS (NUM_INPUTS),
			.OUT_INDEX  (o)
		) u_port_arb (
			.wins (wins),
			.ptr  (out_ptr_s1[o]),
			.gnt  (gnts[o])
		);
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	// output register payload, packed by output index
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			for (int o = 0; o < NUM_OUTPUTS; o++) begin
				gmask_s2[o] <= gnts[o].grant;
				gports_s2[o*INPORT_FIELD_BITS +: INPORT_FIELD_BITS] <= gnts[o].inport;
				gvcs_s2[o*VC_FIELD_BITS +: VC_FIELD_BITS] <= gnts[o].vc;
			end
		end
	end

	assign grant.valid           = v_s2;
	assign grant.grant_mask      = gmask_s2;
	assign grant.granted_inports = gports_s2;
	assign grant.granted_vcs     = gvcs_s2;
endmodule

// File: tb/alloc_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_check_pkg
// beat types and grant scoreboard for the separable switch allocator bench
// ----------------------------------------------------------------------------
package alloc_check_pkg;
	import ssa_pkg::*;

	localparam int N_IN        = DEF_NUM_INPUTS;
	localparam int N_OUT       = DEF_NUM_OUTPUTS;
	localparam int N_VC_PORT   = DEF_VCS_PER_PORT;
	localparam int VC_PER_VNET = DEF_VCS_PER_VNET;
	localparam int AGE_W       = DEF_AGE_BITS;
	localparam int N_VC        = N_IN * N_VC_PORT;
	localparam int N_VNET      = (N_VC_PORT / VC_PER_VNET) < 1 ? 1 : N_VC_PORT / VC_PER_VNET;

	typedef struct packed {
		logic [N_VC-1:0]            request_mask;
		logic [N_VC-1:0]            credit_mask;
		logic [N_VC*ROUTE_BITS-1:0] route_vector;
		logic [N_VC*AGE_W-1:0]      age_vector;
	} req_beat_t;

	typedef struct packed {
		logic [N_OUT-1:0]                   grant_mask;
		logic [N_OUT*INPORT_FIELD_BITS-1:0] granted_inports;
		logic [N_OUT*VC_FIELD_BITS-1:0]     granted_vcs;
	} grant_beat_t;

	class grant_scoreboard;
		int unsigned vc_ptr [N_IN];
		int unsigned port_ptr [N_OUT];
		bit [N_VNET-1:0] ordered_mask;
		grant_beat_t grants_due [$];
		int unsigned mismatches;
		int unsigned beats_seen;
		int unsigned grants_checked;
		int unsigned outputs_granted;

		function void write_mask(logic [N_VNET-1:0] m);
			ordered_mask = m;
		endfunction

		// older requesting sibling of the same vnet heading to the same output
		function bit ordering_blocks(req_beat_t b, int port, int vc, int route, int age);
			int vnet;
			int sib;
			int x;
			vnet = vc / VC_PER_VNET;
			if (vnet >= N_VNET || !ordered_mask[vnet])
				return 1'b0;
			for (int off = 0; off < VC_PER_VNET; off++) begin
				sib = vnet * VC_PER_VNET + off;
				if (sib >= N_VC_PORT)
					continue;
				x = port * N_VC_PORT + sib;
				if (b.request_mask[x] && int'(b.route_vector[x*ROUTE_BITS +: ROUTE_BITS]) == route
						&& int'(b.age_vector[x*AGE_W +: AGE_W]) < age)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_request(req_beat_t b);
			bit [N_IN-1:0] port_req [N_OUT];
			int win_vc [N_OUT][N_IN];
			grant_beat_t g;
			int cand;
			int x;
			int route;
			int age;
			int p;
			g = '0;
			foreach (port_req[o])
				port_req[o] = '0;
			// stage one: one vc per input port
			for (int i = 0; i < N_IN; i++) begin
				cand = int'(vc_ptr[i]);
				vc_ptr[i] = (cand + 1) % N_VC_PORT;
				for (int j = 0; j < N_VC_PORT; j++) begin
					cand = (cand + 1) % N_VC_PORT;
					x = i * N_VC_PORT + cand;
					if (!(b.request_mask[x] && b.credit_mask[x]))
						continue;
					route = int'(b.route_vector[x*ROUTE_BITS +: ROUTE_BITS]);
					if (route >= N_OUT)
						continue;
					age = int'(b.age_vector[x*AGE_W +: AGE_W]);
					if (ordering_blocks(b, i, cand, route, age))
						continue;
					port_req[route][i] = 1'b1;
					win_vc[route][i] = cand;
					break;
				end
			end
			// stage two: one input port per output port
			for (int o = 0; o < N_OUT; o++) begin
				p = int'(port_ptr[o]);
				port_ptr[o] = (p + 1) % N_IN;
				for (int j = 0; j < N_IN; j++) begin
					p = (p + 1) % N_IN;
					if (port_req[o][p]) begin
						g.grant_mask[o] = 1'b1;
						g.granted_inports[o*INPORT_FIELD_BITS +: INPORT_FIELD_BITS] =
							INPORT_FIELD_BITS'(p);
						g.granted_vcs[o*VC_FIELD_BITS +: VC_FIELD_BITS] =
							VC_FIELD_BITS'(win_vc[o][p]);
						break;
					end
				end
			end
			grants_due.push_back(g);
			beats_seen++;
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_grant(grant_beat_t got);
			grant_beat_t want;
			if (grants_due.size() == 0) begin
				report($sformatf("grant beat with nothing pending: %h", got));
				return;
			end
			want = grants_due.pop_front();
			grants_checked++;
			outputs_granted += $countones(want.grant_mask);
			if (got.grant_mask !== want.grant_mask)
				report($sformatf("grant_mask got %b want %b", got.grant_mask, want.grant_mask));
			if (got.granted_inports !== want.granted_inports)
				report($sformatf("granted_inports got %h want %h",
					got.granted_inports, want.granted_inports));
			if (got.granted_vcs !== want.granted_vcs)
				report($sformatf("granted_vcs got %h want %h", got.granted_vcs, want.granted_vcs));
		endtask
	endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the separable switch allocator core
// ----------------------------------------------------------------------------
// request beats go in with random gaps, grant beats come out under random
// back-pressure; a scoreboard predicts each grant beat from the accepted
// request beat and checks every field in order. directed extremes and
// ordered-vnet cases come first, then phases of random traffic under each
// setting of the ordered-vnet mask
// ----------------------------------------------------------------------------
module tb;
	import ssa_pkg::*;
	import alloc_check_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 8;
	localparam int PHASE_BEATS  = 270;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [N_VNET-1:0] cfg_wdata = '0;
	logic              sink_ready = 1'b0;

	// idling on both channels, switched off for one whole phase
	bit                idle_en = 1'b1;
	int unsigned       cycle_count = 0;
	int unsigned       mask_writes = 0;

	grant_scoreboard   sb = new();

	ssa_req_if #(.NUM_VCS(N_VC), .AGE_BITS(AGE_W)) req_if();
	ssa_grant_if #(.NUM_OUTPUTS(N_OUT))            grant_if();

	assign grant_if.ready = sink_ready;

	separable_switch_allocator_core #(
		.NUM_INPUTS  (N_IN),
		.NUM_OUTPUTS (N_OUT),
		.VCS_PER_PORT(N_VC_PORT),
		.VCS_PER_VNET(VC_PER_VNET),
		.AGE_BITS    (AGE_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.grant    (grant_if)
	);

	always #5 clk = ~clk;

	// grant sink: random back-pressure unless idling is off
	always @(posedge clk) begin
		sink_ready <= !idle_en || ($urandom_range(99) >= 33);
	end

	// monitor: both handshakes sampled at the edge, before any drive lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
				sb.note_request({req_if.request_mask, req_if.credit_mask,
					req_if.route_vector, req_if.age_vector});
			if (grant_if.valid === 1'b1 && grant_if.ready === 1'b1)
				sb.check_grant({grant_if.grant_mask, grant_if.granted_inports,
					grant_if.granted_vcs});
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cycle limit hit, %0d grant beats still pending", sb.grants_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// same per-port vc pattern on every input port
	function automatic req_beat_t port_pattern(
		logic [N_VC_PORT-1:0]            rq,
		logic [N_VC_PORT-1:0]            cr,
		logic [N_VC_PORT*ROUTE_BITS-1:0] rt,
		logic [N_VC_PORT*AGE_W-1:0]      ag
	);
		req_beat_t b;
		for (int p = 0; p < N_IN; p++) begin
			b.request_mask[p*N_VC_PORT +: N_VC_PORT]                  = rq;
			b.credit_mask[p*N_VC_PORT +: N_VC_PORT]                   = cr;
			b.route_vector[p*N_VC_PORT*ROUTE_BITS +: N_VC_PORT*ROUTE_BITS] = rt;
			b.age_vector[p*N_VC_PORT*AGE_W +: N_VC_PORT*AGE_W]        = ag;
		end
		return b;
	endfunction

	// random traffic: mostly legal routes with sibling collisions so that the
	// ordering check has work to do; noise beats are fully uniform
	function automatic req_beat_t rand_beat(int density, bit noise);
		req_beat_t b;
		for (int k = 0; k < N_VC; k++) begin
			if (noise) begin
				b.request_mask[k] = 1'($urandom_range(1));
				b.credit_mask[k]  = 1'($urandom_range(1));
				b.route_vector[k*ROUTE_BITS +: ROUTE_BITS] = ROUTE_BITS'($urandom_range(7));
			end else begin
				b.request_mask[k] = $urandom_range(99) < density;
				b.credit_mask[k]  = $urandom_range(99) < 85;
				if (k % VC_PER_VNET != 0 && $urandom_range(1))
					b.route_vector[k*ROUTE_BITS +: ROUTE_BITS] =
						b.route_vector[(k-1)*ROUTE_BITS +: ROUTE_BITS];
				else if ($urandom_range(15) == 0)
					b.route_vector[k*ROUTE_BITS +: ROUTE_BITS] =
						ROUTE_BITS'($urandom_range(7, N_OUT));
				else
					b.route_vector[k*ROUTE_BITS +: ROUTE_BITS] =
						ROUTE_BITS'($urandom_range(N_OUT - 1));
			end
			b.age_vector[k*AGE_W +: AGE_W] = AGE_W'($urandom_range((1 << AGE_W) - 1));
		end
		return b;
	endfunction

	// one request beat, held until the core takes it
	task automatic send_beat(input req_beat_t b);
		if (idle_en) begin
			while ($urandom_range(99) < 33) begin
				req_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_if.valid        <= 1'b1;
		req_if.request_mask <= b.request_mask;
		req_if.credit_mask  <= b.credit_mask;
		req_if.route_vector <= b.route_vector;
		req_if.age_vector   <= b.age_vector;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
	endtask

	// stop sending and let every pending grant beat come out; the first edge
	// makes sure the last accepted beat is already on the scoreboard
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.grants_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_mask(input logic [N_VNET-1:0] m);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		sb.write_mask(m);
		mask_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	logic [N_VNET-1:0] mask_seq [6] = '{'0, '1, N_VNET'(1), N_VNET'(2), '1, '0};

	initial begin
		req_if.valid        <= 1'b0;
		req_if.request_mask <= '0;
		req_if.credit_mask  <= '0;
		req_if.route_vector <= '0;
		req_if.age_vector   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, unordered ----
		write_mask('0);
		send_beat('0);
		// requests without credit, credit without requests
		send_beat(port_pattern('1, '0, '0, '0));
		send_beat(port_pattern('0, '1, '0, '0));
		// every port fights for output 0, pointers rotate
		repeat (3) send_beat(port_pattern('1, '1, '0, '0));
		// highest legal output
		repeat (2) send_beat(port_pattern('1, '1, {N_VC_PORT{3'(N_OUT - 1)}}, '1));
		// out-of-range routes are ignored
		send_beat(port_pattern('1, '1, '1, '0));
		send_beat(port_pattern('1, '1, {N_VC_PORT{3'(N_OUT)}}, '1));
		send_beat('1);

		// ---- directed, ordered ----
		// vc0 older, requesting without credit, same route as vc1: vc1 blocked;
		// vc2/vc3 same route with equal ages: neither blocked
		write_mask('1);
		repeat (4) send_beat(port_pattern(4'b1111, 4'b1110,
			{3'd1, 3'd1, 3'd2, 3'd2}, {3'd3, 3'd3, 3'd5, 3'd0}));
		// ages swapped: vc0 younger, so vc1 goes
		repeat (2) send_beat(port_pattern(4'b1111, 4'b1110,
			{3'd1, 3'd1, 3'd2, 3'd2}, {3'd3, 3'd3, 3'd0, 3'd5}));
		// siblings on different outputs never block
		send_beat(port_pattern(4'b1111, 4'b1111,
			{3'd3, 3'd4, 3'd2, 3'd0}, {3'd0, 3'd7, 3'd0, 3'd7}));
		// older sibling with an out-of-range route blocks only a sibling on that same route
		send_beat(port_pattern(4'b1111, 4'b1111,
			{3'd4, 3'd4, 3'd7, 3'd7}, {3'd7, 3'd0, 3'd7, 3'd0}));
		// each vnet ordered on its own
		write_mask(N_VNET'(1));
		repeat (2) send_beat(port_pattern(4'b1111, 4'b1010,
			{3'd4, 3'd4, 3'd2, 3'd2}, {3'd6, 3'd1, 3'd6, 3'd1}));
		write_mask(N_VNET'(2));
		repeat (2) send_beat(port_pattern(4'b1111, 4'b1010,
			{3'd4, 3'd4, 3'd2, 3'd2}, {3'd6, 3'd1, 3'd6, 3'd1}));

		// ---- random phases ----
		for (int ph = 0; ph < 6; ph++) begin
			write_mask(ph == 5 ? N_VNET'($urandom_range((1 << N_VNET) - 1)) : mask_seq[ph]);
			idle_en <= (ph != 2);
			for (int n = 0; n < PHASE_BEATS; n++)
				send_beat(rand_beat($urandom_range(100), $urandom_range(99) < 15));
		end

		drain();
		idle_en <= 1'b1;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d request beats under %0d mask writes, %0d grant beats checked",
			sb.beats_seen, mask_writes, sb.grants_checked);
		$display("%0d output grants predicted, %0d mismatches, %0d cycles",
			sb.outputs_granted, sb.mismatches, cycle_count);
		if (sb.mismatches == 0 && sb.grants_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
